### hdl/usr_pkg.sv
// Shared types and constants for the USB standard request handler.
// No dependencies; every other file of the block but usr_if uses this package.
package usr_pkg;

  // Interface count and string descriptor limit
  localparam int unsigned NumInterfaces = 3;
  localparam int unsigned MaxStrings    = 8;

  // Standard request codes (bRequest)
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

  // Request types (bmRequestType)
  localparam logic [7:0] RT_OUT_DEV = 8'h00;
  localparam logic [7:0] RT_OUT_IF  = 8'h01;
  localparam logic [7:0] RT_OUT_EP  = 8'h02;
  localparam logic [7:0] RT_IN_DEV  = 8'h80;
  localparam logic [7:0] RT_IN_IF   = 8'h81;
  localparam logic [7:0] RT_IN_EP   = 8'h82;

  // Descriptor types (high byte of wValue)
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  // Endpoint zero actions
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_TRANSMIT = 2'd1;
  localparam logic [1:0] ACT_ADDRESS  = 2'd2;

  // Chosen descriptor
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_DEVICE = 2'd1;
  localparam logic [1:0] KIND_CONFIG = 2'd2;
  localparam logic [1:0] KIND_STRING = 2'd3;

  // Endpoint hardware commands
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_CLEAR     = 2'd1;
  localparam logic [1:0] CMD_STALL     = 2'd2;
  localparam logic [1:0] CMD_CONFIGURE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_DEVICE_DESC_LENGTH     = 3'd0;
  localparam logic [2:0] CFG_CONFIG_DESC_LENGTH     = 3'd1;
  localparam logic [2:0] CFG_ALT_DEVICE_DESC_LENGTH = 3'd2;
  localparam logic [2:0] CFG_ALT_CONFIG_DESC_LENGTH = 3'd3;
  localparam logic [2:0] CFG_STORAGE_PRESENT        = 3'd4;
  localparam logic [2:0] CFG_STRING_COUNT           = 3'd5;
  localparam logic [2:0] CFG_STRING_LENGTHS         = 3'd6;

  // Halt flags: bit0 IN1, bit1 IN2, bit2 IN3, bit3 OUT2, bit4 OUT3
  localparam logic [4:0] HALT_ALL = 5'h1F;

  typedef enum logic [1:0] {
    STATE_DEFAULT    = 2'd0,
    STATE_ADDRESSED  = 2'd1,
    STATE_CONFIGURED = 2'd2
  } dev_state_t;

  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic [4:0]  user_owned_mask;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  ep0_action;
    logic [15:0] reply_length;
    logic [15:0] reply_word;
    logic [1:0]  descriptor_kind;
    logic [7:0]  descriptor_index;
    logic [1:0]  endpoint_command;
    logic [1:0]  endpoint_number;
    logic        endpoint_is_in;
    logic [6:0]  new_address;
    logic [1:0]  device_state;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  device_desc_length;
    logic [15:0] config_desc_length;
    logic [7:0]  alt_device_desc_length;
    logic [15:0] alt_config_desc_length;
    logic        storage_present;
    logic [3:0]  string_count;
    logic [63:0] string_lengths;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
  } ep_sel_t;

  // Map an endpoint address to its halt flag bit
  function automatic ep_sel_t ep_select(input logic [7:0] addr);
    ep_sel_t sel;
    sel = '{ok: 1'b1, idx: 3'd0};
    unique case (addr)
      8'h81:   sel.idx = 3'd0;
      8'h82:   sel.idx = 3'd1;
      8'h83:   sel.idx = 3'd2;
      8'h02:   sel.idx = 3'd3;
      8'h03:   sel.idx = 3'd4;
      default: sel.ok  = 1'b0;
    endcase
    return sel;
  endfunction

endpackage

### hdl/usr_if.sv
// Valid/ready channel interfaces for setup requests and their results.
// Depends on nothing; payload widths follow the request and result fields.
interface usr_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] value_word;
  logic [15:0] index_word;
  logic [15:0] length_word;
  logic [4:0]  user_owned_mask;

  modport source(output valid, output request_type, output request_code,
                 output value_word, output index_word, output length_word,
                 output user_owned_mask, input ready);
  modport sink(input valid, input request_type, input request_code,
               input value_word, input index_word, input length_word,
               input user_owned_mask, output ready);
endinterface

interface usr_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  ep0_action;
  logic [15:0] reply_length;
  logic [15:0] reply_word;
  logic [1:0]  descriptor_kind;
  logic [7:0]  descriptor_index;
  logic [1:0]  endpoint_command;
  logic [1:0]  endpoint_number;
  logic        endpoint_is_in;
  logic [6:0]  new_address;
  logic [1:0]  device_state;

  modport source(output valid, output accepted, output ep0_action,
                 output reply_length, output reply_word, output descriptor_kind,
                 output descriptor_index, output endpoint_command,
                 output endpoint_number, output endpoint_is_in,
                 output new_address, output device_state, input ready);
  modport sink(input valid, input accepted, input ep0_action,
               input reply_length, input reply_word, input descriptor_kind,
               input descriptor_index, input endpoint_command,
               input endpoint_number, input endpoint_is_in,
               input new_address, input device_state, output ready);
endinterface

### hdl/usr_cfg_regs.sv
// Descriptor length and string configuration registers.
// Depends on usr_pkg for the register indexes and the cfg_t bundle.
module usr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_wdata,
  output usr_pkg::cfg_t cfg
);

  usr_pkg::cfg_t cfg_r;
  usr_pkg::cfg_t cfg_nxt;

  // Decode the write into the addressed register; unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        usr_pkg::CFG_DEVICE_DESC_LENGTH:     cfg_nxt.device_desc_length = cfg_wdata[7:0];
        usr_pkg::CFG_CONFIG_DESC_LENGTH:     cfg_nxt.config_desc_length = cfg_wdata[15:0];
        usr_pkg::CFG_ALT_DEVICE_DESC_LENGTH: cfg_nxt.alt_device_desc_length = cfg_wdata[7:0];
        usr_pkg::CFG_ALT_CONFIG_DESC_LENGTH: cfg_nxt.alt_config_desc_length = cfg_wdata[15:0];
        usr_pkg::CFG_STORAGE_PRESENT:        cfg_nxt.storage_present = cfg_wdata[0];
        usr_pkg::CFG_STRING_COUNT:           cfg_nxt.string_count = cfg_wdata[3:0];
        usr_pkg::CFG_STRING_LENGTHS:         cfg_nxt.string_lengths = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_desc_length     <= 8'd18;
      cfg_r.config_desc_length     <= 16'd0;
      cfg_r.alt_device_desc_length <= 8'd18;
      cfg_r.alt_config_desc_length <= 16'd0;
      cfg_r.storage_present        <= 1'b0;
      cfg_r.string_count           <= 4'd0;
      cfg_r.string_lengths         <= 64'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/usr_decode.sv
// Request decoder: checks one setup packet and forms its result and next state.
// Depends on usr_pkg for request codes, types and the ep_select function.
module usr_decode (
  input  usr_pkg::req_t       req,
  input  usr_pkg::cfg_t       cfg,
  input  usr_pkg::dev_state_t state,
  input  logic [4:0]          halt,
  output usr_pkg::rsp_t       rsp,
  output usr_pkg::dev_state_t state_nxt,
  output logic [4:0]          halt_nxt
);

  usr_pkg::ep_sel_t ep_sel;
  logic             configured;
  logic [3:0]       str_limit;
  logic [7:0]       str_idx;
  logic [7:0]       str_size;
  logic [15:0]      desc_size;
  logic             desc_ok;
  logic [1:0]       desc_kind;

  assign ep_sel     = usr_pkg::ep_select(req.index_word[7:0]);
  assign configured = (state == usr_pkg::STATE_CONFIGURED);
  assign str_idx    = req.value_word[7:0];
  assign str_limit  = (cfg.string_count > 4'(usr_pkg::MaxStrings)) ?
                      4'(usr_pkg::MaxStrings) : cfg.string_count;
  assign str_size   = cfg.string_lengths[{str_idx[2:0], 3'b000} +: 8];

  // Pick the descriptor named by wValue and its full length
  always_comb begin
    desc_ok   = 1'b1;
    desc_kind = usr_pkg::KIND_NONE;
    desc_size = 16'd0;
    unique case (req.value_word[15:8])
      usr_pkg::DESC_DEVICE: begin
        desc_kind = usr_pkg::KIND_DEVICE;
        desc_size = {8'd0, cfg.storage_present ? cfg.device_desc_length
                                               : cfg.alt_device_desc_length};
      end
      usr_pkg::DESC_CONFIG: begin
        desc_kind = usr_pkg::KIND_CONFIG;
        desc_size = cfg.storage_present ? cfg.config_desc_length
                                        : cfg.alt_config_desc_length;
      end
      usr_pkg::DESC_STRING: begin
        desc_kind = usr_pkg::KIND_STRING;
        desc_size = {8'd0, str_size};
        desc_ok   = (str_idx < {4'd0, str_limit});
      end
      default: desc_ok = 1'b0;
    endcase
  end

  // Check the request and build the result; a stall leaves all but device_state zero
  always_comb begin
    rsp       = '0;
    state_nxt = state;
    halt_nxt  = halt;
    unique case (req.request_code) inside
      usr_pkg::REQ_GET_STATUS: begin
        if (req.value_word == 16'd0 && req.length_word == 16'd2) begin
          if (req.request_type == usr_pkg::RT_IN_DEV) begin
            rsp.accepted = (req.index_word == 16'd0);
          end else if (req.request_type == usr_pkg::RT_IN_IF) begin
            rsp.accepted = configured &&
                           (req.index_word < 16'(usr_pkg::NumInterfaces));
          end else if (req.request_type == usr_pkg::RT_IN_EP) begin
            rsp.accepted = configured && (req.index_word[15:8] == 8'd0) && ep_sel.ok;
            rsp.reply_word = {15'd0, halt[ep_sel.idx] & rsp.accepted};
          end
          if (rsp.accepted) begin
            rsp.ep0_action   = usr_pkg::ACT_TRANSMIT;
            rsp.reply_length = 16'd2;
          end
        end
      end
      usr_pkg::REQ_CLEAR_FEATURE, usr_pkg::REQ_SET_FEATURE: begin
        if (configured && req.request_type == usr_pkg::RT_OUT_EP &&
            req.value_word == 16'd0 && req.index_word[15:8] == 8'd0 &&
            req.length_word == 16'd0 && ep_sel.ok) begin
          rsp.accepted = 1'b1;
          // Leave endpoints owned by user logic untouched
          if (!req.user_owned_mask[ep_sel.idx]) begin
            rsp.endpoint_number = req.index_word[1:0];
            rsp.endpoint_is_in  = req.index_word[7];
            if (req.request_code == usr_pkg::REQ_CLEAR_FEATURE) begin
              rsp.endpoint_command  = usr_pkg::CMD_CLEAR;
              halt_nxt[ep_sel.idx]  = 1'b0;
            end else begin
              rsp.endpoint_command  = usr_pkg::CMD_STALL;
              halt_nxt[ep_sel.idx]  = 1'b1;
            end
          end
        end
      end
      usr_pkg::REQ_SET_ADDRESS: begin
        if (req.request_type == usr_pkg::RT_OUT_DEV && req.index_word == 16'd0 &&
            req.length_word == 16'd0 && req.value_word[15:7] == 9'd0) begin
          rsp.accepted    = 1'b1;
          rsp.ep0_action  = usr_pkg::ACT_ADDRESS;
          rsp.new_address = req.value_word[6:0];
          state_nxt = (req.value_word[6:0] != 7'd0) ? usr_pkg::STATE_ADDRESSED
                                                    : usr_pkg::STATE_DEFAULT;
        end
      end
      usr_pkg::REQ_GET_DESCRIPTOR: begin
        if (desc_ok) begin
          rsp.accepted        = 1'b1;
          rsp.ep0_action      = usr_pkg::ACT_TRANSMIT;
          rsp.descriptor_kind = desc_kind;
          rsp.reply_length    = (req.length_word < desc_size) ? req.length_word
                                                              : desc_size;
          if (desc_kind == usr_pkg::KIND_STRING) begin
            rsp.descriptor_index = str_idx;
          end
        end
      end
      usr_pkg::REQ_GET_CONFIGURATION: begin
        if (req.request_type == usr_pkg::RT_IN_DEV && req.value_word == 16'd0 &&
            req.index_word == 16'd0 && req.length_word == 16'd1) begin
          rsp.accepted   = 1'b1;
          rsp.ep0_action = usr_pkg::ACT_TRANSMIT;
          // Default state sends an empty data stage
          if (state != usr_pkg::STATE_DEFAULT) begin
            rsp.reply_length = 16'd1;
          end
          rsp.reply_word = {15'd0, configured};
        end
      end
      usr_pkg::REQ_SET_CONFIGURATION: begin
        if (state != usr_pkg::STATE_DEFAULT && req.request_type == usr_pkg::RT_OUT_DEV &&
            req.index_word == 16'd0 && req.length_word == 16'd0 &&
            req.value_word[15:1] == 15'd0) begin
          rsp.accepted = 1'b1;
          if (req.value_word[0]) begin
            rsp.endpoint_command = usr_pkg::CMD_CONFIGURE;
            state_nxt = usr_pkg::STATE_CONFIGURED;
            halt_nxt  = 5'd0;
          end else begin
            state_nxt = usr_pkg::STATE_ADDRESSED;
            halt_nxt  = usr_pkg::HALT_ALL;
          end
        end
      end
      usr_pkg::REQ_GET_INTERFACE: begin
        if (configured && req.request_type == usr_pkg::RT_IN_IF &&
            req.value_word == 16'd0 && req.length_word == 16'd1 &&
            req.index_word < 16'(usr_pkg::NumInterfaces)) begin
          rsp.accepted     = 1'b1;
          rsp.ep0_action   = usr_pkg::ACT_TRANSMIT;
          rsp.reply_length = 16'd1;
        end
      end
      usr_pkg::REQ_SET_INTERFACE: begin
        if (req.request_type == usr_pkg::RT_OUT_IF && req.length_word == 16'd0 &&
            req.value_word == 16'd0 &&
            req.index_word < 16'(usr_pkg::NumInterfaces)) begin
          rsp.accepted         = 1'b1;
          rsp.endpoint_command = usr_pkg::CMD_CONFIGURE;
        end
      end
      default: ;
    endcase
    rsp.device_state = state_nxt;
  end

endmodule

### hdl/usb_standard_request_handler_core.sv
// Top level of the USB standard request handler: input register, decoder,
// device state, result register. Depends on usr_pkg, usr_if, usr_cfg_regs, usr_decode.
//
//  port      dir  kind           carries
//  in_req    in   valid/ready    one setup packet and the user owned endpoint mask
//  out_rsp   out  valid/ready    one result per packet
//  cfg_*     in   write only     descriptor lengths and string table
//
// Each packet passes the input register, the decoder and the result register in
// turn; one packet per cycle sustained while out_rsp.ready stays high.
// Reset (synchronous, rst_n low) clears both stages, returns to the default
// state with every endpoint halted and loads the register defaults.
// A stalled result register holds the input register; in_req.ready then drops.
module usb_standard_request_handler_core (
  input  logic         clk,
  input  logic         rst_n,
  usr_req_if.sink      in_req,
  usr_rsp_if.source    out_rsp,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  usr_pkg::cfg_t       cfg;
  usr_pkg::req_t       in_payload;
  usr_pkg::req_t       s1_req_r;
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  usr_pkg::rsp_t       out_rsp_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  usr_pkg::dev_state_t state_r;
  usr_pkg::dev_state_t state_nxt;
  logic [4:0]          halt_r;
  logic [4:0]          halt_nxt;
  usr_pkg::rsp_t       dec_rsp;
  logic                out_free;
  logic                s1_go;
  logic                in_fire;

  usr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  usr_decode u_decode (
    .req       (s1_req_r),
    .cfg       (cfg),
    .state     (state_r),
    .halt      (halt_r),
    .rsp       (dec_rsp),
    .state_nxt (state_nxt),
    .halt_nxt  (halt_nxt)
  );

  assign in_payload = '{
    request_type:    in_req.request_type,
    request_code:    in_req.request_code,
    value_word:      in_req.value_word,
    index_word:      in_req.index_word,
    length_word:     in_req.length_word,
    user_owned_mask: in_req.user_owned_mask
  };

  // Advance the input stage whenever the result register frees up
  assign out_free      = !out_valid_r || out_rsp.ready;
  assign s1_go         = s1_valid_r && out_free;
  assign in_req.ready  = !s1_valid_r || out_free;
  assign in_fire       = in_req.valid && in_req.ready;
  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_rsp.ready ? 1'b0 : out_valid_r);

  // Control state and device state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= usr_pkg::STATE_DEFAULT;
      halt_r      <= usr_pkg::HALT_ALL;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        state_r <= state_nxt;
        halt_r  <= halt_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_payload;
    end
    if (s1_go) begin
      out_rsp_r <= dec_rsp;
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.accepted         = out_rsp_r.accepted;
  assign out_rsp.ep0_action       = out_rsp_r.ep0_action;
  assign out_rsp.reply_length     = out_rsp_r.reply_length;
  assign out_rsp.reply_word       = out_rsp_r.reply_word;
  assign out_rsp.descriptor_kind  = out_rsp_r.descriptor_kind;
  assign out_rsp.descriptor_index = out_rsp_r.descriptor_index;
  assign out_rsp.endpoint_command = out_rsp_r.endpoint_command;
  assign out_rsp.endpoint_number  = out_rsp_r.endpoint_number;
  assign out_rsp.endpoint_is_in   = out_rsp_r.endpoint_is_in;
  assign out_rsp.new_address      = out_rsp_r.new_address;
  assign out_rsp.device_state     = out_rsp_r.device_state;

endmodule
